// ===== rtl/dnrm_pkg.sv =====
`default_nettype none
package dnrm_pkg;

  localparam int MaxRefs  = 256;
  localparam int MaxDim   = 64;
  localparam int RefW     = $clog2(MaxRefs);
  localparam int DimW     = $clog2(MaxDim);
  localparam int RcntW    = RefW + 1;
  localparam int AddrW    = RefW + DimW;
  localparam int SumW     = 40;
  localparam int RootW    = SumW / 2;
  localparam logic [19:0] ScoreSat = 20'hFFFFF;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_REF   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MAC,
    ST_CMP,
    ST_SQ1,
    ST_SQ2,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/descriptor_nearest_ratio_match.sv =====
// search: the last query element starts a search over all stored references with one
// multiply-accumulate unit, then a square root (two roots and a divide in ratio mode)
// throughput: one request at a time; not ready while a search runs or a result waits
// reset: counters and mode registers clear, desc_len goes to 64; stores stay undefined
`default_nettype none
module descriptor_nearest_ratio_match
  import dnrm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic signed [15:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      query_index,
  output logic [7:0]       best_ref,
  output logic [19:0]      score,
  output logic             no_ref
);

  state_t state, state_next;

  logic              match_mode;
  logic [6:0]        desc_len;
  logic [RcntW-1:0]  ref_count;
  logic [DimW-1:0]   elem_count;
  logic [15:0]       query_count;

  logic signed [15:0] ref_store [MaxRefs*MaxDim];
  logic signed [15:0] query_buf [MaxDim];
  logic signed [15:0] ref_rd, q_rd;

  logic [RcntW-1:0]  r_idx;
  logic [DimW:0]     e_idx;
  logic [SumW-1:0]   acc, best, second;
  logic              have_best, have_second;
  logic              have_second_n;
  logic [RefW-1:0]   best_idx;
  logic [SumW-1:0]   sq_x, sq_res, sq_bit;
  logic              sq_phase;
  logic [RootW-1:0]  d1;
  logic [RootW+16:0] rem;
  logic [RootW+16:0] quo;
  logic [RootW-1:0]  divisor;
  logic [5:0]        div_cnt;

  logic [DimW:0]     len;
  logic [DimW-1:0]   wpos;
  logic              last_pos;
  logic              accept;
  logic signed [16:0] diff;
  logic [15:0]       adiff;
  logic [31:0]       prod;

  // effective descriptor length
  always_comb begin
    if (desc_len == 7'd0) len = (DimW+1)'(1);
    else if (desc_len > 7'(MaxDim)) len = (DimW+1)'(MaxDim);
    else len = desc_len[DimW:0];
  end

  // element position, held at the last slot after a length change
  assign wpos = ((DimW+1)'(elem_count) >= len) ? DimW'(len - 1'b1) : elem_count;
  assign last_pos = ((DimW+1)'(wpos) + 1'b1) >= len;
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign diff     = 17'(q_rd) - 17'(ref_rd);
  assign adiff    = diff[16] ? 16'(-diff) : diff[15:0];
  assign prod     = {16'd0, adiff} * {16'd0, adiff};
  // a second best exists once this compare has seen two references
  assign have_second_n = have_second || have_best;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode <= 1'b0;
      desc_len   <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) match_mode <= cfg_data[0];
      else desc_len <= cfg_data;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_REF && ref_count < RcntW'(MaxRefs))
      ref_store[{ref_count[RefW-1:0], wpos}] <= value;
    if (accept && kind == KIND_QUERY)
      query_buf[wpos] <= value;
    ref_rd <= ref_store[{r_idx[RefW-1:0], e_idx[DimW-1:0]}];
    q_rd   <= query_buf[e_idx[DimW-1:0]];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && kind == KIND_QUERY && last_pos) begin
        state_next = (ref_count == '0) ? ST_OUT : ST_RD;
      end
      ST_RD:  state_next = ST_MAC;
      ST_MAC: if (e_idx >= len) state_next = ST_CMP;
      ST_CMP: begin
        if (r_idx + 1'b1 < ref_count) state_next = ST_RD;
        else if (match_mode == 1'b0) state_next = ST_SQ1;
        else if (!have_second_n) state_next = ST_OUT;
        else state_next = ST_SQ1;
      end
      ST_SQ1: if (sq_bit == '0) state_next = ST_SQ2;
      ST_SQ2: state_next = (match_mode && !sq_phase) ? ST_SQ1
                         : (match_mode ? ST_DIV : ST_OUT);
      ST_DIV: if (div_cnt == 6'd0) state_next = ST_OUT;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count   <= '0;
      elem_count  <= '0;
      query_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) begin
          unique case (kind_t'(kind))
            KIND_CLEAR: begin
              ref_count  <= '0;
              elem_count <= '0;
            end
            KIND_REF: if (ref_count < RcntW'(MaxRefs)) begin
              if (last_pos) begin
                elem_count <= '0;
                ref_count  <= ref_count + 1'b1;
              end else elem_count <= wpos + 1'b1;
            end
            KIND_QUERY: begin
              if (last_pos) begin
                elem_count  <= '0;
                r_idx       <= '0;
                e_idx       <= '0;
                acc         <= '0;
                have_best   <= 1'b0;
                have_second <= 1'b0;
                best_idx    <= '0;
                sq_phase    <= 1'b0;
                no_ref      <= (ref_count == '0);
                best_ref    <= '0;
                score       <= ScoreSat;
                query_index <= query_count;
                if (ref_count == '0) out_valid <= 1'b1;
              end else elem_count <= wpos + 1'b1;
            end
            KIND_NONE: ;
            default: ;
          endcase
        end
        ST_RD: e_idx <= e_idx + 1'b1;
        ST_MAC: begin
          acc <= acc + SumW'(prod);
          if (e_idx < len) e_idx <= e_idx + 1'b1;
        end
        ST_CMP: begin
          // best and second-best update, strict less-than
          if (!have_best || acc < best) begin
            if (have_best) begin
              second <= best;
              have_second <= 1'b1;
            end
            best      <= acc;
            best_idx  <= r_idx[RefW-1:0];
            have_best <= 1'b1;
          end else if (!have_second || acc < second) begin
            second <= acc;
            have_second <= 1'b1;
          end
          acc   <= '0;
          e_idx <= '0;
          r_idx <= r_idx + 1'b1;
          // set up the square root of the best sum
          sq_x   <= (!have_best || acc < best) ? acc : best;
          sq_res <= '0;
          sq_bit <= SumW'(1) << (SumW-2);
          best_ref <= 8'((!have_best || acc < best) ? r_idx[RefW-1:0] : best_idx);
          if (r_idx + 1'b1 >= ref_count && match_mode && !have_second_n) begin
            score     <= '0;
            out_valid <= 1'b1;
          end
        end
        ST_SQ1: begin
          // one digit-pair step of the integer root
          if (sq_bit != '0) begin
            if (sq_x >= sq_res + sq_bit) begin
              sq_x   <= sq_x - (sq_res + sq_bit);
              sq_res <= (sq_res >> 1) + sq_bit;
            end else sq_res <= sq_res >> 1;
            sq_bit <= sq_bit >> 2;
          end
        end
        ST_SQ2: begin
          if (!match_mode) begin
            score     <= sq_res[19:0];
            out_valid <= 1'b1;
          end else if (!sq_phase) begin
            d1       <= sq_res[RootW-1:0];
            sq_phase <= 1'b1;
            sq_x     <= second;
            sq_res   <= '0;
            sq_bit   <= SumW'(1) << (SumW-2);
          end else begin
            divisor <= sq_res[RootW-1:0];
            rem     <= '0;
            quo     <= {d1, 16'd0, 1'b0};
            div_cnt <= 6'(RootW + 16);
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (div_cnt == 6'd0) begin
            score     <= (divisor == '0) ? 20'd65536 : quo[19:0];
            out_valid <= 1'b1;
          end else if (divisor == '0) begin
            div_cnt <= '0;
          end else begin
            if ({rem[RootW+15:0], quo[RootW+16]} >= (RootW+17)'(divisor)) begin
              rem <= {rem[RootW+15:0], quo[RootW+16]} - (RootW+17)'(divisor);
              quo <= {quo[RootW+15:0], 1'b1};
            end else begin
              rem <= {rem[RootW+15:0], quo[RootW+16]};
              quo <= {quo[RootW+15:0], 1'b0};
            end
            div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_OUT: if (out_ready) begin
          out_valid   <= 1'b0;
          query_count <= query_count + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/descriptor_nearest_ratio_match_tb.sv =====
`default_nettype none

// expected match result for one completed query
typedef struct {
  logic [15:0] query_index;
  logic [7:0]  best_ref;
  logic [19:0] score;
  logic        no_ref;
} match_t;

class match_scoreboard;
  localparam int NREF = dnrm_pkg::MaxRefs;
  localparam int NDIM = dnrm_pkg::MaxDim;

  // mirrored block state
  bit              ratio_mode;
  logic [6:0]      len_reg;
  logic signed [15:0] ref_mem [NREF*NDIM];
  logic signed [15:0] qbuf [NDIM];
  bit              ref_wr [NREF*NDIM];
  bit              q_wr [NDIM];
  int unsigned     ref_cnt;
  int unsigned     elem_pos;
  logic [15:0]     query_cnt;

  match_t matches_due[$];
  int     mismatches;

  function new();
    ratio_mode = 0;
    len_reg    = 7'd64;
    ref_cnt    = 0;
    elem_pos   = 0;
    query_cnt  = 0;
    mismatches = 0;
    foreach (ref_wr[i]) ref_wr[i] = 0;
    foreach (q_wr[i]) q_wr[i] = 0;
  endfunction

  function int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > NDIM) return NDIM;
    return len_reg;
  endfunction

  function void set_reg(bit idx, logic [6:0] data);
    if (idx == 1'b0) ratio_mode = data[0];
    else len_reg = data;
  endfunction

  function int pending();
    return matches_due.size();
  endfunction

  function logic signed [15:0] ref_elem(int r, int e);
    return ref_mem[r*NDIM + e];
  endfunction

  // a query that completes now would read an entry never written
  function bit reads_unwritten(dnrm_pkg::kind_t k);
    int unsigned len, pos;
    len = eff_len();
    pos = (elem_pos >= len) ? len - 1 : elem_pos;
    if (k != dnrm_pkg::KIND_QUERY || pos + 1 < len) return 0;
    for (int e = 0; e < len; e++)
      if (e != pos && !q_wr[e]) return 1;
    for (int r = 0; r < ref_cnt; r++)
      for (int e = 0; e < len; e++)
        if (!ref_wr[r*NDIM + e]) return 1;
    return 0;
  endfunction

  // integer square root, rounded down
  function logic [19:0] floor_root(logic [47:0] x);
    logic [19:0] r, t;
    r = 0;
    for (int b = 19; b >= 0; b--) begin
      t = r | (20'd1 << b);
      if ({28'd0, t} * {28'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  // take one accepted request, queue the result it causes
  function void note_request(dnrm_pkg::kind_t k, logic signed [15:0] v);
    int unsigned len, pos, best_idx;
    logic [47:0] s, best, second;
    bit have_best, have_second;
    logic [19:0] d1, d2;
    int diff;
    match_t m;
    len = eff_len();
    pos = (elem_pos >= len) ? len - 1 : elem_pos;
    case (k)
      dnrm_pkg::KIND_CLEAR: begin
        ref_cnt  = 0;
        elem_pos = 0;
      end
      dnrm_pkg::KIND_REF: begin
        if (ref_cnt < NREF) begin
          ref_mem[ref_cnt*NDIM + pos] = v;
          ref_wr[ref_cnt*NDIM + pos]  = 1;
          if (pos + 1 >= len) begin
            elem_pos = 0;
            ref_cnt++;
          end else begin
            elem_pos = pos + 1;
          end
        end
      end
      dnrm_pkg::KIND_QUERY: begin
        qbuf[pos] = v;
        q_wr[pos] = 1;
        if (pos + 1 < len) begin
          elem_pos = pos + 1;
        end else begin
          elem_pos = 0;
          have_best = 0;
          have_second = 0;
          best = 0;
          second = 0;
          best_idx = 0;
          // nearest and second-nearest over exact squared sums
          for (int r = 0; r < ref_cnt; r++) begin
            s = 0;
            for (int e = 0; e < len; e++) begin
              diff = int'(qbuf[e]) - int'(ref_mem[r*NDIM + e]);
              if (diff < 0) diff = -diff;
              s += 48'(diff) * 48'(diff);
            end
            if (!have_best || s < best) begin
              if (have_best) begin
                second = best;
                have_second = 1;
              end
              best = s;
              best_idx = r;
              have_best = 1;
            end else if (!have_second || s < second) begin
              second = s;
              have_second = 1;
            end
          end
          m.query_index = query_cnt;
          m.best_ref    = best_idx[7:0];
          m.no_ref      = !have_best;
          if (!have_best) begin
            m.score = dnrm_pkg::ScoreSat;
          end else if (!ratio_mode) begin
            m.score = floor_root(best);
          end else if (!have_second) begin
            m.score = 0;
          end else begin
            d1 = floor_root(best);
            d2 = floor_root(second);
            m.score = (d2 == 0) ? 20'd65536 : 20'(({28'd0, d1} << 16) / {28'd0, d2});
          end
          matches_due.insert(matches_due.size(), m);
          query_cnt++;
        end
      end
      default: ;
    endcase
  endfunction

  // compare one accepted result with the oldest expectation
  function void check_match(match_t got);
    match_t w;
    if (matches_due.size() == 0) begin
      $error("result with no query waiting: index %0d", got.query_index);
      mismatches++;
      return;
    end
    w = matches_due.pop_front();
    if (got.query_index !== w.query_index) begin
      $error("query_index: expected %0d, actual %0d", w.query_index, got.query_index);
      mismatches++;
    end
    if (got.best_ref !== w.best_ref) begin
      $error("best_ref: expected %0d, actual %0d", w.best_ref, got.best_ref);
      mismatches++;
    end
    if (got.score !== w.score) begin
      $error("score: expected %0d, actual %0d", w.score, got.score);
      mismatches++;
    end
    if (got.no_ref !== w.no_ref) begin
      $error("no_ref: expected %0d, actual %0d", w.no_ref, got.no_ref);
      mismatches++;
    end
  endfunction
endclass

module descriptor_nearest_ratio_match_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dnrm_pkg::*;

  localparam bit CFG_MODE   = 1'b0;
  localparam bit CFG_LEN    = 1'b1;
  localparam bit MODE_DIST  = 1'b0;
  localparam bit MODE_RATIO = 1'b1;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = 1'b0;
  logic [6:0] cfg_data = 7'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = KIND_NONE;
  logic signed [15:0] value = 16'sd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] query_index;
  logic [7:0] best_ref;
  logic [19:0] score;
  logic no_ref;

  match_scoreboard sb;
  int sent_items = 0;
  int send_idle = 30;
  int recv_stall = 49;
  int hold_left = 0;
  bit hold_done = 0;
  int cycles = 0;
  bit stim_running = 1;

  descriptor_nearest_ratio_match DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .query_index(query_index), .best_ref(best_ref), .score(score), .no_ref(no_ref)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!hold_done && sent_items >= 400) begin
      hold_done = 1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // result monitor
  always @(posedge clk) begin
    match_t got;
    if (!rst && out_valid && out_ready) begin
      got.query_index = query_index;
      got.best_ref    = best_ref;
      got.score       = score;
      got.no_ref      = no_ref;
      sb.check_match(got);
    end
  end

  // idling schedule follows progress
  always @(posedge clk) begin
    if (sent_items >= 1100) begin
      send_idle  <= 0;
      recv_stall <= 0;
    end else if (sent_items >= 550) begin
      send_idle  <= 49;
      recv_stall <= 30;
    end
  end

  function automatic logic signed [15:0] pick_val();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3, 4: return 16'($urandom_range(0, 255)) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  // one request through the valid/ready handshake
  task automatic send(kind_t k, logic signed [15:0] v);
    kind_t kk;
    kk = k;
    if (sb.reads_unwritten(kk)) kk = KIND_CLEAR;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= kk;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kk, v);
    if (kk != KIND_NONE) sent_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, logic [6:0] data);
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(bit mode, logic [6:0] len);
    wait_drained();
    write_reg(CFG_MODE, 7'(mode));
    write_reg(CFG_LEN, len);
  endtask

  // whole descriptor: random, copy of a stored reference, or a near copy
  task automatic send_desc(kind_t k, int src);
    int style;
    logic signed [15:0] v;
    style = (sb.ref_cnt == 0 || src < 0) ? 0 : $urandom_range(0, 2);
    for (int e = 0; e < sb.eff_len(); e++) begin
      case (style)
        1: v = sb.ref_elem(src, e);
        2: v = sb.ref_elem(src, e) + 16'($urandom_range(0, 6)) - 16'sd3;
        default: v = pick_val();
      endcase
      send(k, v);
    end
  endtask

  // mostly load-then-query sequences, some noise and broken sequences
  task automatic random_phase(int n_items, int max_refs);
    int stop, nref, nq;
    stop = sent_items + n_items;
    while (sent_items < stop) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 4) == 0) send(KIND_CLEAR, pick_val());
        nref = $urandom_range(0, max_refs);
        repeat (nref)
          send_desc(KIND_REF, (sb.ref_cnt > 0) ? $urandom_range(0, sb.ref_cnt - 1) : -1);
        nq = $urandom_range(1, 3);
        repeat (nq)
          send_desc(KIND_QUERY, (sb.ref_cnt > 0) ? $urandom_range(0, sb.ref_cnt - 1) : -1);
      end else begin
        repeat ($urandom_range(1, 4))
          send(kind_t'($urandom_range(0, 3)), pick_val());
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: two-element descriptors
    set_config(MODE_DIST, 7'd2);
    send(KIND_NONE, 16'sd1234);
    send(KIND_QUERY, 16'sd5);
    send(KIND_QUERY, -16'sd5);          // no reference loaded
    send(KIND_REF, -16'sd32768);
    send(KIND_REF, 16'sd32767);
    send(KIND_QUERY, 16'sd32767);
    send(KIND_QUERY, -16'sd32768);      // largest distance
    set_config(MODE_RATIO, 7'd2);
    send(KIND_QUERY, 16'sd100);
    send(KIND_QUERY, -16'sd100);        // single reference gives zero ratio
    send(KIND_REF, -16'sd32768);
    send(KIND_REF, 16'sd32767);
    send(KIND_QUERY, -16'sd32768);
    send(KIND_QUERY, 16'sd32767);       // tie at zero distance
    send(KIND_CLEAR, 16'sd0);
    send(KIND_REF, 16'sd300);
    send(KIND_REF, -16'sd200);
    send(KIND_REF, 16'sd1000);
    send(KIND_REF, 16'sd900);
    send(KIND_QUERY, 16'sd350);
    send(KIND_QUERY, -16'sd150);

    // random phases over several lengths and both modes
    set_config(MODE_DIST, 7'd5);
    send(KIND_CLEAR, 16'sd0);
    random_phase(350, 6);
    set_config(MODE_RATIO, 7'd3);
    send(KIND_CLEAR, 16'sd0);
    random_phase(300, 8);
    set_config(MODE_DIST, 7'd127);
    send(KIND_CLEAR, 16'sd0);
    random_phase(260, 2);

    // full store with zero length acting as one, sender pauses first
    set_config(MODE_RATIO, 7'd0);
    send(KIND_CLEAR, 16'sd0);
    repeat (260) send(KIND_REF, pick_val());
    repeat (3) send_desc(KIND_QUERY, $urandom_range(0, 255));

    set_config(MODE_RATIO, 7'd17);
    send(KIND_CLEAR, 16'sd0);
    random_phase(200, 4);
    set_config(MODE_DIST, 7'd1);
    send(KIND_CLEAR, 16'sd0);
    random_phase(150, 10);
    set_config(MODE_RATIO, 7'd64);
    send(KIND_CLEAR, 16'sd0);
    random_phase(120, 2);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

`default_nettype wire
